// ===== rtl/mosaic_pkg.sv =====
// ----------------------------------------------------------------------------
// mosaic_pkg
// shared constants for the mosaic pixelation block: register indexes,
// register widths and reset values, pixel channel width
// ----------------------------------------------------------------------------
package mosaic_pkg;

    localparam int PIX_W      = 8;
    localparam int STEP_W     = $clog2(PIX_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_REG_W = 11;
    localparam int BLK_REG_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;

    localparam int IMAGE_WIDTH_RST  = 640;
    localparam int IMAGE_HEIGHT_RST = 480;
    localparam int BLOCK_SIZE_RST   = 8;

endpackage

// ===== rtl/mosaic_fifo.sv =====
// ----------------------------------------------------------------------------
// mosaic_fifo
// small queue of finished block sums between the accumulator and the divider
// ----------------------------------------------------------------------------
module mosaic_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_next;
    logic [AW:0]       count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mosaic_front.sv =====
// ----------------------------------------------------------------------------
// mosaic_front
// raster position tracking and per block column channel sums; a pixel is
// read from the sum memory in the cycle it is taken and written back in the
// update phase, and a finished block is pushed into the queue
// ----------------------------------------------------------------------------
module mosaic_front
    import mosaic_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 64,
    parameter int ENT_W      = 95
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(MAX_WIDTH):0]   img_w,
    input  logic [$clog2(MAX_HEIGHT):0]  img_h,
    input  logic [$clog2(MAX_BLOCK):0]   blk_size,
    input  logic                         restart,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [PIX_W-1:0]             red,
    input  logic [PIX_W-1:0]             green,
    input  logic [PIX_W-1:0]             blue,
    output logic                         push,
    output logic [ENT_W-1:0]             push_data,
    input  logic                         fifo_full
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_BLOCK);
    localparam int BLK_W = CW + 1;
    localparam int SUM_W = PIX_W + 2 * CW;

    localparam logic PH_TAKE   = 1'b0;
    localparam logic PH_UPDATE = 1'b1;

    typedef struct packed {
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
        logic [BLK_W-1:0] w;
        logic [BLK_W-1:0] h;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic             last;
    } ent_t;

    logic [3*SUM_W-1:0] mem [MAX_WIDTH];

    logic               phase_reg;
    logic               phase_next;
    logic [XW-1:0]      col_reg;
    logic [XW-1:0]      col_next;
    logic [YW-1:0]      row_reg;
    logic [YW-1:0]      row_next;
    logic [CW-1:0]      cib_reg;
    logic [CW-1:0]      cib_next;
    logic [CW-1:0]      rib_reg;
    logic [CW-1:0]      rib_next;
    logic [XW-1:0]      bci_reg;
    logic [XW-1:0]      bci_next;

    // per word latched at accept
    logic [PIX_W-1:0]   pr_reg;
    logic [PIX_W-1:0]   pg_reg;
    logic [PIX_W-1:0]   pb_reg;
    logic [XW-1:0]      idx_reg;
    logic               fresh_reg;
    logic               done_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [BLK_W-1:0]   bw_reg;
    logic [BLK_W-1:0]   bh_reg;
    logic               last_reg;
    logic [3*SUM_W-1:0] rdata_reg;

    logic               accept;
    logic               step_ok;
    logic [XW:0]        pc1;
    logic [YW:0]        pr1;
    logic [CW:0]        cb1;
    logic [CW:0]        rb1;
    logic               row_last;
    logic               frame_end;
    logic               blk_col_end;
    logic               blk_row_end;
    logic               col_end;
    logic               row_end;
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    ent_t               ent;

    assign in_stall = (phase_reg == PH_UPDATE);
    assign accept   = in_valid && (phase_reg == PH_TAKE);
    assign step_ok  = (phase_reg == PH_UPDATE) && (!done_reg || !fifo_full);
    assign push     = (phase_reg == PH_UPDATE) && done_reg && !fifo_full;

    assign pc1         = {1'b0, col_reg} + 1'b1;
    assign pr1         = {1'b0, row_reg} + 1'b1;
    assign cb1         = {1'b0, cib_reg} + 1'b1;
    assign rb1         = {1'b0, rib_reg} + 1'b1;
    assign row_last    = (pc1 >= img_w);
    assign frame_end   = (pr1 >= img_h);
    assign blk_col_end = (cb1 >= blk_size);
    assign blk_row_end = (rb1 >= blk_size);
    assign col_end     = row_last || blk_col_end;
    assign row_end     = frame_end || blk_row_end;

    // first pixel of a block loads the sums
    assign sum_r = fresh_reg ? SUM_W'(pr_reg)
                             : rdata_reg[3*SUM_W-1 -: SUM_W] + SUM_W'(pr_reg);
    assign sum_g = fresh_reg ? SUM_W'(pg_reg)
                             : rdata_reg[2*SUM_W-1 -: SUM_W] + SUM_W'(pg_reg);
    assign sum_b = fresh_reg ? SUM_W'(pb_reg)
                             : rdata_reg[SUM_W-1:0] + SUM_W'(pb_reg);

    always_comb
    begin
        ent.x     = x_reg;
        ent.y     = y_reg;
        ent.w     = bw_reg;
        ent.h     = bh_reg;
        ent.sum_r = sum_r;
        ent.sum_g = sum_g;
        ent.sum_b = sum_b;
        ent.last  = last_reg;
    end

    assign push_data = ENT_W'(ent);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        cib_next   = cib_reg;
        rib_next   = rib_reg;
        bci_next   = bci_reg;
        phase_next = phase_reg;
        case (phase_reg)
            PH_TAKE:
            begin
                if (accept)
                begin
                    phase_next = PH_UPDATE;
                end
            end
            PH_UPDATE:
            begin
                if (step_ok)
                begin
                    phase_next = PH_TAKE;
                end
            end
            default: phase_next = PH_TAKE;
        endcase
        if (accept)
        begin
            if (row_last)
            begin
                col_next = '0;
                cib_next = '0;
                bci_next = '0;
                if (frame_end)
                begin
                    row_next = '0;
                    rib_next = '0;
                end
                else
                begin
                    row_next = pr1[YW-1:0];
                    rib_next = blk_row_end ? '0 : rb1[CW-1:0];
                end
            end
            else
            begin
                col_next = pc1[XW-1:0];
                if (blk_col_end)
                begin
                    cib_next = '0;
                    bci_next = bci_reg + 1'b1;
                end
                else
                begin
                    cib_next = cb1[CW-1:0];
                end
            end
        end
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
            cib_next = '0;
            rib_next = '0;
            bci_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAKE;
            col_reg   <= '0;
            row_reg   <= '0;
            cib_reg   <= '0;
            rib_reg   <= '0;
            bci_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cib_reg   <= cib_next;
            rib_reg   <= rib_next;
            bci_reg   <= bci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pr_reg    <= red;
            pg_reg    <= green;
            pb_reg    <= blue;
            idx_reg   <= bci_reg;
            fresh_reg <= (cib_reg == '0) && (rib_reg == '0);
            done_reg  <= col_end && row_end;
            x_reg     <= col_reg - XW'(cib_reg);
            y_reg     <= row_reg - YW'(rib_reg);
            bw_reg    <= cb1;
            bh_reg    <= rb1;
            last_reg  <= row_last && frame_end;
            rdata_reg <= mem[bci_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_ok)
        begin
            mem[idx_reg] <= {sum_r, sum_g, sum_b};
        end
    end

endmodule

// ===== rtl/mosaic_back.sv =====
// ----------------------------------------------------------------------------
// mosaic_back
// takes finished block sums from the queue, forms the area and divides the
// three sums by it one quotient bit per cycle, then loads the result register
// ----------------------------------------------------------------------------
module mosaic_back
    import mosaic_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 64,
    parameter int ENT_W      = 95
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fifo_empty,
    input  logic [ENT_W-1:0]              pop_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]  block_x,
    output logic [$clog2(MAX_HEIGHT)-1:0] block_y,
    output logic [$clog2(MAX_BLOCK):0]    block_w,
    output logic [$clog2(MAX_BLOCK):0]    block_h,
    output logic [PIX_W-1:0]              avg_red,
    output logic [PIX_W-1:0]              avg_green,
    output logic [PIX_W-1:0]              avg_blue,
    output logic                          frame_last
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int CW     = $clog2(MAX_BLOCK);
    localparam int BLK_W  = CW + 1;
    localparam int SUM_W  = PIX_W + 2 * CW;
    localparam int AREA_W = 2 * BLK_W;
    localparam int DSH_W  = AREA_W + PIX_W - 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_AREA = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    typedef struct packed {
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
        logic [BLK_W-1:0] w;
        logic [BLK_W-1:0] h;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic             last;
    } ent_t;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    ent_t              ent_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [SUM_W-1:0]  rem_r_reg;
    logic [SUM_W-1:0]  rem_g_reg;
    logic [SUM_W-1:0]  rem_b_reg;
    logic [PIX_W-1:0]  q_r_reg;
    logic [PIX_W-1:0]  q_g_reg;
    logic [PIX_W-1:0]  q_b_reg;
    logic              ov_reg;
    logic [XW-1:0]     bx_reg;
    logic [YW-1:0]     by_reg;
    logic [BLK_W-1:0]  bw_reg;
    logic [BLK_W-1:0]  bh_reg;
    logic [PIX_W-1:0]  ar_reg;
    logic [PIX_W-1:0]  ag_reg;
    logic [PIX_W-1:0]  ab_reg;
    logic              fl_reg;

    logic [AREA_W-1:0] area;
    logic              ge_r;
    logic              ge_g;
    logic              ge_b;
    logic              load_out;
    logic              out_taken;

    assign area      = AREA_W'(ent_reg.w) * AREA_W'(ent_reg.h);
    assign ge_r      = (DSH_W'(rem_r_reg) >= dsh_reg);
    assign ge_g      = (DSH_W'(rem_g_reg) >= dsh_reg);
    assign ge_b      = (DSH_W'(rem_b_reg) >= dsh_reg);
    assign pop       = (state_reg == B_IDLE) && !fifo_empty;
    assign out_taken = ov_reg && !out_stall;
    assign load_out  = (state_reg == B_DONE) && (!ov_reg || !out_stall);

    assign out_valid  = ov_reg;
    assign block_x    = bx_reg;
    assign block_y    = by_reg;
    assign block_w    = bw_reg;
    assign block_h    = bh_reg;
    assign avg_red    = ar_reg;
    assign avg_green  = ag_reg;
    assign avg_blue   = ab_reg;
    assign frame_last = fl_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = B_AREA;
                end
            end
            B_AREA: state_next = B_DIV;
            B_DIV:
            begin
                if (step_reg == STEP_W'(PIX_W - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // restoring division, quotient known to fit in a pixel
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    ent_reg <= ent_t'(pop_data);
                end
            end
            B_AREA:
            begin
                dsh_reg   <= {area, {(PIX_W - 1){1'b0}}};
                rem_r_reg <= ent_reg.sum_r;
                rem_g_reg <= ent_reg.sum_g;
                rem_b_reg <= ent_reg.sum_b;
            end
            B_DIV:
            begin
                dsh_reg <= dsh_reg >> 1;
                q_r_reg <= {q_r_reg[PIX_W-2:0], ge_r};
                q_g_reg <= {q_g_reg[PIX_W-2:0], ge_g};
                q_b_reg <= {q_b_reg[PIX_W-2:0], ge_b};
                if (ge_r)
                begin
                    rem_r_reg <= rem_r_reg - SUM_W'(dsh_reg);
                end
                if (ge_g)
                begin
                    rem_g_reg <= rem_g_reg - SUM_W'(dsh_reg);
                end
                if (ge_b)
                begin
                    rem_b_reg <= rem_b_reg - SUM_W'(dsh_reg);
                end
            end
            default:
            begin
                dsh_reg <= dsh_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            bx_reg <= ent_reg.x;
            by_reg <= ent_reg.y;
            bw_reg <= ent_reg.w;
            bh_reg <= ent_reg.h;
            ar_reg <= q_r_reg;
            ag_reg <= q_g_reg;
            ab_reg <= q_b_reg;
            fl_reg <= ent_reg.last;
        end
    end

endmodule

// ===== rtl/block_mosaic_pixelate_core.sv =====
// ----------------------------------------------------------------------------
// block_mosaic_pixelate_core
// mosaic pixelation by block averaging of a raster-order rgb stream
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we                  cfg_index, cfg_data
//   in       in         in_valid / in_stall     red, green, blue
//   out      out        out_valid / out_stall   block_x/y/w/h, avg_*, frame_last
//
// a pixel word goes through a take and an update phase: the column sum memory is
// read when the word is taken and written back in the update phase; a
// block-ending word holds in the update phase while the queue is full
// a block result goes through the divider as pop, area, 8 quotient steps and
// load; a 4-entry queue lets the two sides stall on their own
// the sum memory needs no clearing pass, so pixels are taken right after reset
// ----------------------------------------------------------------------------
module block_mosaic_pixelate_core
    import mosaic_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PIX_W-1:0]              red,
    input  logic [PIX_W-1:0]              green,
    input  logic [PIX_W-1:0]              blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]  block_x,
    output logic [$clog2(MAX_HEIGHT)-1:0] block_y,
    output logic [$clog2(MAX_BLOCK):0]    block_w,
    output logic [$clog2(MAX_BLOCK):0]    block_h,
    output logic [PIX_W-1:0]              avg_red,
    output logic [PIX_W-1:0]              avg_green,
    output logic [PIX_W-1:0]              avg_blue,
    output logic                          frame_last
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int CW      = $clog2(MAX_BLOCK);
    localparam int WW      = XW + 1;
    localparam int HW      = YW + 1;
    localparam int BLK_W   = CW + 1;
    localparam int SUM_W   = PIX_W + 2 * CW;
    localparam int ENT_W   = XW + YW + 2 * BLK_W + 3 * SUM_W + 1;
    localparam int Q_DEPTH = 4;

    localparam int W_RST = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;
    localparam int H_RST = (IMAGE_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RST;
    localparam int B_RST = (BLOCK_SIZE_RST > MAX_BLOCK) ? MAX_BLOCK : BLOCK_SIZE_RST;

    logic [WW-1:0]         img_w_reg;
    logic [HW-1:0]         img_h_reg;
    logic [BLK_W-1:0]      blk_size_reg;
    logic [WW-1:0]         img_w_next;
    logic [HW-1:0]         img_h_next;
    logic [BLK_W-1:0]      blk_size_next;
    logic [SIZE_REG_W-1:0] size_val;
    logic [BLK_REG_W-1:0]  blk_val;
    logic                  restart;

    logic                  push;
    logic [ENT_W-1:0]      push_data;
    logic                  pop;
    logic [ENT_W-1:0]      pop_data;
    logic                  fifo_full;
    logic                  fifo_empty;

    assign size_val = cfg_data[SIZE_REG_W-1:0];
    assign blk_val  = cfg_data[BLK_REG_W-1:0];
    assign restart  = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
                              || (cfg_index == REG_IMAGE_HEIGHT)
                              || (cfg_index == REG_BLOCK_SIZE));

    // zero acts as one, large values saturate
    always_comb
    begin
        img_w_next    = img_w_reg;
        img_h_next    = img_h_reg;
        blk_size_next = blk_size_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (size_val == '0)
                        img_w_next = WW'(1);
                    else if (32'(size_val) > MAX_WIDTH)
                        img_w_next = WW'(MAX_WIDTH);
                    else
                        img_w_next = WW'(size_val);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (size_val == '0)
                        img_h_next = HW'(1);
                    else if (32'(size_val) > MAX_HEIGHT)
                        img_h_next = HW'(MAX_HEIGHT);
                    else
                        img_h_next = HW'(size_val);
                end
                REG_BLOCK_SIZE:
                begin
                    if (blk_val == '0)
                        blk_size_next = BLK_W'(1);
                    else if (32'(blk_val) > MAX_BLOCK)
                        blk_size_next = BLK_W'(MAX_BLOCK);
                    else
                        blk_size_next = BLK_W'(blk_val);
                end
                default:
                begin
                    img_w_next = img_w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= WW'(W_RST);
            img_h_reg    <= HW'(H_RST);
            blk_size_reg <= BLK_W'(B_RST);
        end
        else
        begin
            img_w_reg    <= img_w_next;
            img_h_reg    <= img_h_next;
            blk_size_reg <= blk_size_next;
        end
    end

    mosaic_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCK  (MAX_BLOCK),
        .ENT_W      (ENT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .img_w      (img_w_reg),
        .img_h      (img_h_reg),
        .blk_size   (blk_size_reg),
        .restart    (restart),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .push       (push),
        .push_data  (push_data),
        .fifo_full  (fifo_full)
    );

    mosaic_fifo #(
        .DATA_W     (ENT_W),
        .DEPTH      (Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    mosaic_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCK  (MAX_BLOCK),
        .ENT_W      (ENT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_x    (block_x),
        .block_y    (block_y),
        .block_w    (block_w),
        .block_h    (block_h),
        .avg_red    (avg_red),
        .avg_green  (avg_green),
        .avg_blue   (avg_blue),
        .frame_last (frame_last)
    );

endmodule
